// ===== hw/rtl/pip_pkg.sv =====
// Shared types and codes for the point in polygon test block.
`timescale 1ns / 1ps
package pip_pkg;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic CFG_COARSE = 1'b0;
  localparam logic CFG_FINE   = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] y_second;
    logic signed [31:0] x_second;
    logic signed [31:0] y_first;
    logic signed [31:0] x_first;
  } item_t;

  typedef struct packed {
    logic       orientation_valid;
    logic       clockwise;
    logic [8:0] crossing_count;
    logic       on_boundary;
    logic       inside_res;
  } res_t;

endpackage

// ===== hw/rtl/pip_ram.sv =====
// Generic single write port memory with a registered read port.
`timescale 1ns / 1ps
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

// ===== hw/rtl/pip_front.sv =====
// Front end: accepts input transfers, drops unknown kinds and queues the rest.
`timescale 1ns / 1ps
module pip_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [127:0]   in_tdata,
  input  logic [1:0]     in_tuser,
  output logic           q_valid,
  output pip_pkg::item_t q_item,
  input  logic           q_pop
);
  import pip_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] n_r;
  logic       push;
  item_t      item_in;

  always_comb begin
    item_in.kind     = in_tuser;
    item_in.x_first  = $signed(in_tdata[31:0]);
    item_in.y_first  = $signed(in_tdata[63:32]);
    item_in.x_second = $signed(in_tdata[95:64]);
    item_in.y_second = $signed(in_tdata[127:96]);
  end

  assign in_tready = (n_r != 2'd2);
  assign push      = in_tvalid && in_tready && (in_tuser != KIND_NONE);
  assign q_valid   = (n_r != 2'd0);
  assign q_item    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item_in;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      n_r <= n_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== hw/rtl/pip_back.sv =====
// Back end: segment store, query walk pipeline and result register.
`timescale 1ns / 1ps
module pip_back #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    coarse_tol,
  input  logic [15:0]    fine_tol,
  input  logic           q_valid,
  input  pip_pkg::item_t q_item,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output pip_pkg::res_t  res
);
  import pip_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int TW = 68 + AW;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_r;
  logic [CW-1:0]      cnt_r;
  logic [AW-1:0]      i_r;
  logic signed [31:0] px_r, py_r;

  // Store access
  logic               wr_en;
  logic [127:0]       seg_rd;
  logic [31:0]        yj_rd;
  logic [CW-1:0]      i_next;
  logic [AW-1:0]      j_addr;

  assign q_pop  = (state_r == ST_IDLE) && q_valid;
  assign wr_en  = q_pop && (q_item.kind == KIND_APPEND) && (cnt_r < CW'(MAX_SEGMENTS));
  assign i_next = CW'(i_r) + CW'(1);
  assign j_addr = (i_next < cnt_r) ? i_next[AW-1:0] : '0;

  pip_ram #(.WIDTH(128), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(cnt_r[AW-1:0]),
    .wr_data({q_item.y_second, q_item.x_second, q_item.y_first, q_item.x_first}),
    .rd_addr(i_r), .rd_data(seg_rd)
  );

  pip_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_endy_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(cnt_r[AW-1:0]),
    .wr_data(q_item.y_second), .rd_addr(j_addr), .rd_data(yj_rd)
  );

  logic          rd_v_r;
  logic [AW-1:0] rd_idx_r;

  // Stage 1: differences, tolerance bands and classification
  logic signed [31:0] x1, y1, x2, y2, yj, p0x, p0y;
  logic signed [32:0] d1, d2, dy, ad1, ad2, ady, a_v, b_v, dxe, pxx, wx, wy;
  logic signed [31:0] lo, hi, xl, xh;
  logic signed [34:0] tcw;
  logic signed [33:0] den0, num0;
  logic               skip, is_v1, is_v2, is_h;

  assign x1 = $signed(seg_rd[31:0]);
  assign y1 = $signed(seg_rd[63:32]);
  assign x2 = $signed(seg_rd[95:64]);
  assign y2 = $signed(seg_rd[127:96]);
  assign yj = $signed(yj_rd);

  logic signed [31:0] p0x_r, p0y_r;
  logic signed [32:0] vx_r, vy_r;

  always_comb begin
    d1   = 33'(py_r) - 33'(y1);
    d2   = 33'(py_r) - 33'(y2);
    dy   = 33'(y1) - 33'(y2);
    ad1  = (d1 < 0) ? -d1 : d1;
    ad2  = (d2 < 0) ? -d2 : d2;
    ady  = (dy < 0) ? -dy : dy;
    lo   = (y1 < y2) ? y1 : y2;
    hi   = (y1 < y2) ? y2 : y1;
    xl   = (x1 < x2) ? x1 : x2;
    xh   = (x1 < x2) ? x2 : x1;
    tcw  = $signed({19'd0, coarse_tol});
    skip = (35'(py_r) < 35'(lo) - tcw) || (35'(py_r) > 35'(hi) + tcw);
    is_v1 = $unsigned(ad1) < 33'(coarse_tol);
    is_v2 = $unsigned(ad2) < 33'(coarse_tol);
    is_h  = $unsigned(ady) < 33'(coarse_tol);
    den0 = 34'(y2) - 34'(y1);
    num0 = 34'(d1);
    dxe  = 33'(x2) - 33'(x1);
    pxx  = 33'(px_r) - 33'(x1);
    a_v  = 33'(yj) - 33'(y2);
    b_v  = dy;
    p0x  = (rd_idx_r == '0) ? x1 : p0x_r;
    p0y  = (rd_idx_r == '0) ? y1 : p0y_r;
    wx   = 33'(x2) - 33'(p0x);
    wy   = 33'(y2) - 33'(p0y);
  end

  logic               s1_v_r, s1_inc_r, s1_bnd_r, s1_gen_r, s1_same_r, s1_term_r;
  logic signed [33:0] s1_num_r, s1_den_r;
  logic signed [32:0] s1_dxe_r, s1_pxx_r, s1_wx_r, s1_wy_r, s1_vx_r, s1_vy_r;

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      s1_inc_r  <= !skip && is_v1 && (px_r < x1);
      s1_bnd_r  <= !skip && !is_v1 && !is_v2 && is_h && (px_r > xl) && (px_r < xh);
      s1_gen_r  <= !skip && !is_v1 && !is_v2 && !is_h;
      s1_same_r <= ((a_v > 0) && (b_v > 0)) || ((a_v < 0) && (b_v < 0));
      s1_term_r <= (rd_idx_r != '0) && ((CW'(rd_idx_r) + CW'(1)) < cnt_r);
      s1_num_r  <= (den0 < 0) ? -num0 : num0;
      s1_den_r  <= (den0 < 0) ? -den0 : den0;
      s1_dxe_r  <= dxe;
      s1_pxx_r  <= pxx;
      s1_wx_r   <= wx;
      s1_wy_r   <= wy;
      s1_vx_r   <= vx_r;
      s1_vy_r   <= vy_r;
      vx_r      <= wx;
      vy_r      <= wy;
      p0x_r     <= p0x;
      p0y_r     <= p0y;
    end
  end

  // Stage 2: products
  logic               s2_v_r, s2_inc_r, s2_bnd_r, s2_gen_r, s2_same_r, s2_term_r;
  logic signed [66:0] s2_m1_r, s2_m2_r;
  logic signed [49:0] s2_scaled_r;
  logic signed [51:0] s2_tcden_r, s2_hiden_r, s2_lim_r;
  logic signed [65:0] s2_o1_r, s2_o2_r;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_inc_r    <= s1_inc_r;
      s2_bnd_r    <= s1_bnd_r;
      s2_gen_r    <= s1_gen_r;
      s2_same_r   <= s1_same_r;
      s2_term_r   <= s1_term_r;
      s2_m1_r     <= s1_num_r * s1_dxe_r;
      s2_m2_r     <= s1_pxx_r * s1_den_r;
      s2_scaled_r <= {s1_num_r, 16'd0};
      s2_tcden_r  <= $signed({1'b0, coarse_tol}) * s1_den_r;
      s2_hiden_r  <= ($signed(18'sd65536) - $signed({2'b0, coarse_tol})) * s1_den_r;
      s2_lim_r    <= $signed({1'b0, fine_tol}) * s1_den_r;
      s2_o1_r     <= s1_vx_r * s1_wy_r;
      s2_o2_r     <= s1_vy_r * s1_wx_r;
    end
  end

  // Stage 3: difference and band compares
  logic               s3_v_r, s3_inc_r, s3_bnd_r, s3_gen_r, s3_same_r, s3_term_r;
  logic               s3_lt_r, s3_gt_r;
  logic signed [67:0] s3_diff_r, s3_lim_r;
  logic signed [66:0] s3_o_r;

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      s3_inc_r  <= s2_inc_r;
      s3_bnd_r  <= s2_bnd_r;
      s3_gen_r  <= s2_gen_r;
      s3_same_r <= s2_same_r;
      s3_term_r <= s2_term_r;
      s3_lt_r   <= 52'(s2_scaled_r) < s2_tcden_r;
      s3_gt_r   <= 52'(s2_scaled_r) > s2_hiden_r;
      s3_diff_r <= 68'(s2_m1_r) - 68'(s2_m2_r);
      s3_lim_r  <= 68'(s2_lim_r);
      s3_o_r    <= 67'(s2_o1_r) - 67'(s2_o2_r);
    end
  end

  // Stage 4: crossing decision and accumulation
  logic               inc, bnd;
  logic [8:0]         count_r;
  logic               bnd_r;
  logic signed [TW-1:0] total_r;

  always_comb begin
    inc = 1'b0;
    bnd = 1'b0;
    if (s3_gen_r) begin
      if (s3_lt_r) begin
        inc = 1'b0;
      end else if (s3_gt_r) begin
        inc = !s3_same_r && (s3_diff_r > 0);
      end else if ((s3_diff_r < s3_lim_r) && (s3_diff_r > -s3_lim_r)) begin
        bnd = 1'b1;
      end else begin
        inc = s3_diff_r > 0;
      end
    end else begin
      inc = s3_inc_r;
      bnd = s3_bnd_r;
    end
  end

  logic res_valid_r;
  res_t res_r;
  logic pipe_busy, load;

  assign pipe_busy = rd_v_r || s1_v_r || s2_v_r || s3_v_r;
  assign load      = (state_r == ST_FIN) && !pipe_busy && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (q_pop && (q_item.kind == KIND_QUERY)) begin
      px_r <= q_item.x_first;
      py_r <= q_item.y_first;
    end
    if (state_r == ST_WALK) begin
      rd_idx_r <= i_r;
    end
    if (load) begin
      res_r.on_boundary       <= bnd_r;
      res_r.crossing_count    <= bnd_r ? 9'd0 : count_r;
      res_r.inside_res        <= bnd_r || count_r[0];
      res_r.orientation_valid <= cnt_r >= CW'(3);
      res_r.clockwise         <= (cnt_r >= CW'(3)) && !(total_r > 0);
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      i_r         <= '0;
      rd_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      res_valid_r <= 1'b0;
      count_r     <= '0;
      bnd_r       <= 1'b0;
      total_r     <= '0;
    end else begin
      rd_v_r <= (state_r == ST_WALK);
      s1_v_r <= rd_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (s3_v_r) begin
        if (!bnd_r) begin
          count_r <= count_r + {8'd0, inc};
          bnd_r   <= bnd;
        end
        if (s3_term_r) begin
          total_r <= total_r + TW'(s3_o_r);
        end
      end
      if (load) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_item.kind)
              KIND_CLEAR: cnt_r <= '0;
              KIND_APPEND: begin
                if (wr_en) begin
                  cnt_r <= cnt_r + CW'(1);
                end
              end
              KIND_QUERY: begin
                count_r <= '0;
                bnd_r   <= 1'b0;
                total_r <= '0;
                i_r     <= '0;
                state_r <= (cnt_r == '0) ? ST_FIN : ST_WALK;
              end
              default: cnt_r <= cnt_r;
            endcase
          end
        end
        ST_WALK: begin
          if (i_next == cnt_r) begin
            state_r <= ST_FIN;
          end else begin
            i_r <= i_next[AW-1:0];
          end
        end
        ST_FIN: begin
          if (load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pipe_busy)
    else $error("walk pipeline still busy while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SEGMENTS))
    else $error("segment count above capacity");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (CW'(i_r) < cnt_r))
    else $error("walk address beyond stored segments");

  a_boundary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.on_boundary) |-> (res_r.crossing_count == 9'd0 && res_r.inside_res))
    else $error("boundary result with crossings");
endmodule

// ===== hw/rtl/polygon_point_inside_test.sv =====
// Top level of the point in polygon test block.
`timescale 1ns / 1ps
// Usage: the input stream carries one command per transfer, its kind in
// in_tuser: clear the contour, append one segment (start and end point in
// Q16.16), or query a point. Clear and append give no result; a query gives
// exactly one result transfer on the output stream. Two tolerances are set
// through the configuration write channel; the user must do so only while
// the block is idle; the block does not enforce it. Commands pass through
// a two-entry queue into the back end, so the input side can fill that queue
// while a query is walked or a result waits. The back end takes a clear or
// an append while it is idle. A query reads the stored segments one per
// cycle from the segment memory, the memory read port setting the pace;
// its result loads into the output register once the walk pipeline is empty.
// When the receiver stalls, the result is held in the output register and
// the back end waits before loading the next one; queued commands wait too.
// Reset empties the contour and the queue and restores the tolerances
// to 66 and 1; the segment memory is not cleared and needs no clearing pass.
module polygon_point_inside_test #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // x_first, y_first, x_second, y_second
  input  logic [1:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  // inside_res, on_boundary, crossing_count, clockwise, orientation_valid, zero pad
  output logic [15:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import pip_pkg::*;

  logic [15:0] coarse_r, fine_r;
  logic        q_valid, q_pop;
  item_t       q_item;
  res_t        res;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_r <= 16'd66;
      fine_r   <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index[0])
        CFG_COARSE: coarse_r <= cfg_data;
        CFG_FINE:   fine_r   <= cfg_data;
        default:    fine_r   <= fine_r;
      endcase
    end
  end

  pip_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  pip_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .coarse_tol(coarse_r), .fine_tol(fine_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  // The result fields sit from the highest used bit down in declaration order.
  assign out_tdata = {3'd0, res.orientation_valid, res.clockwise,
                      res.crossing_count, res.on_boundary, res.inside_res};
endmodule

// ===== tb/polygon_point_inside_test_checker.sv =====
// Checker for the point in polygon block: predicts every query result and compares it.
`timescale 1ns / 1ps
module polygon_point_inside_test_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [15:0]  out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending_count
);
  import pip_pkg::*;

  localparam int CAPACITY = 256;

  longint seg_x1 [CAPACITY];
  longint seg_y1 [CAPACITY];
  longint seg_x2 [CAPACITY];
  longint seg_y2 [CAPACITY];
  int     seg_total;
  longint tol_coarse;
  longint tol_fine;
  res_t   awaited_results [$];

  function automatic logic signed [127:0] wide_mul(longint a, longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Ray cast toward +x from the point, plus fan orientation of the contour.
  function automatic res_t crossing_result(longint px, longint py);
    res_t r;
    int unsigned count;
    bit on_edge;
    longint x1, y1, x2, y2, lo, hi, d1, d2, dy, xl, xh, num, den, scaled, a, b;
    logic signed [127:0] diff, lim, fan_sum;
    longint vx, vy, wx, wy;
    int j;
    count = 0;
    on_edge = 0;
    for (int i = 0; i < seg_total && !on_edge; i++) begin
      x1 = seg_x1[i]; y1 = seg_y1[i]; x2 = seg_x2[i]; y2 = seg_y2[i];
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      d1 = py - y1; d2 = py - y2; dy = y1 - y2;
      if (py < lo - tol_coarse || py > hi + tol_coarse) continue;
      if (mag(d1) < tol_coarse) begin
        if (px < x1) count++;
      end else if (mag(d2) < tol_coarse) begin
        continue;
      end else if (mag(dy) < tol_coarse) begin
        // Near-horizontal edge: only a point strictly between its ends is on it.
        xl = (x1 < x2) ? x1 : x2;
        xh = (x1 < x2) ? x2 : x1;
        if (px > xl && px < xh) on_edge = 1;
      end else begin
        num = d1;
        den = y2 - y1;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        scaled = num * 65536;
        if (scaled < tol_coarse * den) continue;
        diff = wide_mul(num, x2 - x1) - wide_mul(px - x1, den);
        if (scaled > (65536 - tol_coarse) * den) begin
          // Close to the end vertex: skip it when the contour turns back.
          j = (i + 1 < seg_total) ? i + 1 : 0;
          a = seg_y2[j] - y2;
          b = y1 - y2;
          if (!((a > 0 && b > 0) || (a < 0 && b < 0)) && diff > 0) count++;
        end else begin
          lim = wide_mul(tol_fine, den);
          if (diff < lim && -lim < diff) on_edge = 1;
          else if (diff > 0) count++;
        end
      end
    end
    r = '0;
    if (seg_total >= 3) begin
      vx = seg_x2[0] - seg_x1[0];
      vy = seg_y2[0] - seg_y1[0];
      fan_sum = 0;
      for (int i = 1; i + 1 < seg_total; i++) begin
        wx = seg_x2[i] - seg_x1[0];
        wy = seg_y2[i] - seg_y1[0];
        fan_sum = fan_sum + wide_mul(vx, wy) - wide_mul(vy, wx);
        vx = wx;
        vy = wy;
      end
      r.orientation_valid = 1'b1;
      r.clockwise = !(fan_sum > 0);
    end
    if (on_edge) count = 0;
    r.inside_res = on_edge || count[0];
    r.on_boundary = on_edge;
    r.crossing_count = count[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      seg_total = 0;
      tol_coarse = 66;
      tol_fine = 1;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COARSE) tol_coarse = cfg_data;
        else tol_fine = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[12:0];
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.inside_res !== want.inside_res) begin
            $error("inside_res expected %0d got %0d", want.inside_res, got.inside_res);
            fail_count++;
          end
          if (got.on_boundary !== want.on_boundary) begin
            $error("on_boundary expected %0d got %0d", want.on_boundary, got.on_boundary);
            fail_count++;
          end
          if (got.crossing_count !== want.crossing_count) begin
            $error("crossing_count expected %0d got %0d",
                   want.crossing_count, got.crossing_count);
            fail_count++;
          end
          if (got.clockwise !== want.clockwise) begin
            $error("clockwise expected %0d got %0d", want.clockwise, got.clockwise);
            fail_count++;
          end
          if (got.orientation_valid !== want.orientation_valid) begin
            $error("orientation_valid expected %0d got %0d",
                   want.orientation_valid, got.orientation_valid);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          KIND_CLEAR: seg_total = 0;
          KIND_APPEND: begin
            if (seg_total < CAPACITY) begin
              seg_x1[seg_total] = $signed(in_tdata[31:0]);
              seg_y1[seg_total] = $signed(in_tdata[63:32]);
              seg_x2[seg_total] = $signed(in_tdata[95:64]);
              seg_y2[seg_total] = $signed(in_tdata[127:96]);
              seg_total++;
            end
          end
          KIND_QUERY: begin
            want = crossing_result($signed(in_tdata[31:0]), $signed(in_tdata[63:32]));
            awaited_results = {awaited_results, want};
          end
          default: ;
        endcase
      end
    end
    pending_count = awaited_results.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

endmodule

// ===== tb/polygon_point_inside_test_tb.sv =====
// Testbench top for the point in polygon block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module polygon_point_inside_test_tb;
  import pip_pkg::*;

  // The cycle limit allows many times the length of the whole run.
  localparam int LIMIT       = 3000000;
  localparam int DRAIN_WAIT  = 300;
  localparam int LONG_HOLD   = 600;
  localparam longint UNIT    = 65536;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [0:0]   cfg_index;
  logic [15:0]  cfg_data;
  int           fail_count;
  int           pending_count;
  int           cycle_count;
  bit           calm;
  bit           hold_req;

  // Vertices of the contour currently being built.
  longint poly_x [256];
  longint poly_y [256];

  polygon_point_inside_test u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  polygon_point_inside_test_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("[polygon_point_inside_test] ERROR");
      $finish;
    end
  end

  // Receiver: short random stalls, one long hold-off on request, none once calm.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // One input transfer; valid stays high into the next transfer unless a gap is drawn.
  task automatic send(logic [1:0] kind, longint xf, longint yf, longint xs, longint ys);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {ys[31:0], xs[31:0], yf[31:0], xf[31:0]};
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  endtask

  // Stop offering input and wait for every result, then for the back end to go quiet.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_tolerances(logic [15:0] coarse, logic [15:0] fine);
    wait_drained();
    write_reg(CFG_COARSE, coarse);
    write_reg(CFG_FINE, fine);
  endtask

  // Coordinates: a coarse grid gives many shared vertices and level edges,
  // the wide form reaches every bit of the field.
  function automatic longint pick_coord(int mode);
    case (mode)
      0:       return (longint'($urandom_range(0, 8)) - 4) * UNIT;
      1:       return longint'($urandom_range(0, 2097152)) - 1048576;
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  function automatic longint wrap32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  task automatic send_contour(int nv);
    for (int i = 0; i < nv; i++)
      send(KIND_APPEND, poly_x[i], poly_y[i], poly_x[(i + 1) % nv], poly_y[(i + 1) % nv]);
  endtask

  // Query points near the contour: vertices, edge midpoints, nudged points, free points.
  task automatic query_near(int nv, int mode);
    int k;
    longint qx, qy;
    k = $urandom_range(0, nv - 1);
    case ($urandom_range(0, 4))
      0: begin qx = poly_x[k]; qy = poly_y[k]; end
      1: begin
        qx = (poly_x[k] + poly_x[(k + 1) % nv]) >>> 1;
        qy = (poly_y[k] + poly_y[(k + 1) % nv]) >>> 1;
      end
      2: begin
        qx = wrap32(poly_x[k] + longint'($urandom_range(0, 200)) - 100);
        qy = wrap32(poly_y[k] + longint'($urandom_range(0, 200)) - 100);
      end
      default: begin qx = pick_coord(mode); qy = pick_coord(mode); end
    endcase
    send(KIND_QUERY, qx, qy, pick_coord(2), pick_coord(2));
  endtask

  // One random phase: mostly closed contours with queries, some broken input.
  task automatic random_phase(int items);
    int sent, nv, mode, r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 9);
      mode = $urandom_range(0, 2);
      if (r < 7) begin
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
        for (int i = 0; i < nv; i++) begin
          poly_x[i] = pick_coord(mode);
          poly_y[i] = pick_coord(mode);
        end
        send(KIND_CLEAR, pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2));
        send_contour(nv);
        sent += nv + 1;
        repeat ($urandom_range(3, 10)) begin
          query_near(nv, mode);
          sent++;
        end
      end else if (r == 7) begin
        // An open chain of loose segments added to whatever is stored.
        repeat ($urandom_range(1, 4)) begin
          send(KIND_APPEND, pick_coord(mode), pick_coord(mode), pick_coord(mode),
               pick_coord(mode));
          sent++;
        end
        send(KIND_QUERY, pick_coord(mode), pick_coord(mode), 0, 0);
        sent++;
      end else if (r == 8) begin
        send(KIND_NONE, pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2));
      end else begin
        send(KIND_QUERY, pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_CLEAR;
    cfg_valid = 1'b0;
    cfg_index = CFG_COARSE;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty contour, short contour, a square of side 4 units with its special points.
    send(KIND_QUERY, 0, 0, 0, 0);
    send(KIND_APPEND, 0, 0, 4 * UNIT, 0);
    send(KIND_APPEND, 4 * UNIT, 0, 4 * UNIT, 4 * UNIT);
    send(KIND_QUERY, UNIT, UNIT, 0, 0);
    send(KIND_APPEND, 4 * UNIT, 4 * UNIT, 0, 4 * UNIT);
    send(KIND_APPEND, 0, 4 * UNIT, 0, 0);
    send(KIND_QUERY, UNIT, UNIT, 0, 0);                // inside
    send(KIND_QUERY, -UNIT, UNIT, 0, 0);               // outside, two crossings
    send(KIND_QUERY, 2 * UNIT, 4 * UNIT, 0, 0);        // on a level edge
    send(KIND_QUERY, 4 * UNIT, 2 * UNIT, 0, 0);        // on a steep edge
    send(KIND_QUERY, 0, 0, 0, 0);                      // on a vertex
    send(KIND_QUERY, 2 * UNIT, 4 * UNIT - 50, 0, 0);   // within the coarse band
    send(KIND_NONE, -1, -1, -1, -1);                   // ignored kind
    send(KIND_CLEAR, 0, 0, 0, 0);
    // Clockwise triangle at the extremes of the coordinate range.
    send(KIND_APPEND, -2147483648, -2147483648, -2147483648, 2147483647);
    send(KIND_APPEND, -2147483648, 2147483647, 2147483647, 2147483647);
    send(KIND_APPEND, 2147483647, 2147483647, -2147483648, -2147483648);
    send(KIND_QUERY, -2147483648, 0, 0, 0);
    send(KIND_QUERY, 0, 1000, 0, 0);
    send(KIND_QUERY, 2147483647, -2147483648, 0, 0);

    random_phase(150);
    set_tolerances(16'd0, 16'd0);
    random_phase(150);

    // Fill the store past capacity; the extra append is dropped.
    send(KIND_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 257; i++) begin
      poly_x[i % 256] = pick_coord(1);
      poly_y[i % 256] = pick_coord(1);
      send(KIND_APPEND, pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1));
    end
    repeat (4) send(KIND_QUERY, pick_coord(1), pick_coord(1), 0, 0);

    set_tolerances(16'd65535, 16'd65535);
    random_phase(100);

    // Long receiver hold-off while small queries keep coming, so the input stalls.
    send(KIND_CLEAR, 0, 0, 0, 0);
    poly_x[0] = 0; poly_y[0] = 0;
    poly_x[1] = 3 * UNIT; poly_y[1] = UNIT;
    poly_x[2] = UNIT; poly_y[2] = 3 * UNIT;
    send_contour(3);
    hold_req = 1'b1;
    repeat (12) query_near(3, 0);

    set_tolerances(16'($urandom()), 16'($urandom()));
    random_phase(150);
    set_tolerances(16'd2000, 16'd300);
    random_phase(150);
    set_tolerances(16'd66, 16'd1);
    calm = 1'b1;
    random_phase(150);

    wait_drained();
    if (fail_count == 0)
      $display("[polygon_point_inside_test] OK");
    else
      $display("[polygon_point_inside_test] ERROR");
    $finish;
  end

endmodule
